FILE: rtl/jls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types and constants of the Jacobi Laplace sweep block.
// ----------------------------------------------------------------------------
package jls_pkg;

  // stream field layout
  localparam int IDX_W       = 6;
  localparam int CELL_W      = 32;
  localparam int OP_W        = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int ROW_LSB     = 0;
  localparam int COL_LSB     = ROW_LSB + IDX_W;
  localparam int VAL_LSB     = COL_LSB + IDX_W;

  // configuration port
  localparam int              CFG_IDX_W       = 1;
  localparam int              CFG_DATA_W      = 7;
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_ROWS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_GRID_COLS   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] GRID_SIZE_RESET = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_SWEEP = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic latch_item;
    logic sweep_start;
    logic access;
    logic sweep_step;
    logic swap;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic pipe_empty;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/jls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_ctrl
// Sequencer: takes one item, steps the datapath through access or sweep,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module jls_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire jls_pkg::op_t     in_op,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  input  wire jls_pkg::status_t status,
  output jls_pkg::cmd_t         cmd
);
  import jls_pkg::*;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;
  logic   accept;
  logic   slot_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_op == OP_SWEEP) ? ST_SWEEP : ST_ACCESS;
        end
      end
      ST_ACCESS: state_nxt = ST_RESULT;
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.latch_item  = accept;
        cmd.sweep_start = accept && (in_op == OP_SWEEP);
      end
      ST_ACCESS: cmd.access     = 1'b1;
      ST_SWEEP:  cmd.sweep_step = 1'b1;
      ST_DRAIN:  cmd.swap       = status.pipe_empty;
      ST_RESULT: cmd.load_out   = slot_free;
      default:   cmd            = '0;
    endcase
    out_tvalid_nxt = cmd.load_out || (out_tvalid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/jls_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jls_datapath
// Two grid buffers, raster read stream with a two-row line buffer,
// five-point stencil pipeline, change tracking and the result register.
// ----------------------------------------------------------------------------
module jls_datapath #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire jls_pkg::cmd_t                    cmd,
  output jls_pkg::status_t                      status,
  input  wire jls_pkg::op_t                     in_op,
  input  wire logic [jls_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [jls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [jls_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [jls_pkg::CELL_W-1:0]            read_value,
  output logic [jls_pkg::CELL_W-1:0]            max_change,
  output logic                                  bad_address
);
  import jls_pkg::*;

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int SZR   = ($clog2(MAX_ROWS + 1) > CFG_DATA_W) ? $clog2(MAX_ROWS + 1) : CFG_DATA_W;
  localparam int SZW   = ($clog2(MAX_COLS + 1) > SZR) ? $clog2(MAX_COLS + 1) : SZR;
  localparam int TAPS  = 2 * MAX_COLS + 1;
  localparam int MW    = (VALUE_BITS > CELL_W) ? VALUE_BITS : CELL_W;

  // configuration
  logic [CFG_DATA_W-1:0] grid_rows_r, grid_cols_r;
  logic [SZW-1:0]        used_rows, used_cols, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_SIZE_RESET;
      grid_cols_r <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_ROWS: grid_rows_r <= cfg_data;
        REG_GRID_COLS: grid_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign used_rows = (SZW'(grid_rows_r) > SZW'(MAX_ROWS)) ? SZW'(MAX_ROWS) : SZW'(grid_rows_r);
  assign used_cols = (SZW'(grid_cols_r) > SZW'(MAX_COLS)) ? SZW'(MAX_COLS) : SZW'(grid_cols_r);
  assign last_row  = (used_rows == '0) ? '0 : used_rows - SZW'(1);

  // latched item
  op_t                     item_op_r;
  logic [IDX_W-1:0]        item_row_r, item_col_r;
  logic signed [CELL_W-1:0] item_val_r;
  logic [AW-1:0]           item_addr;
  logic                    item_bad;
  logic signed [MW-1:0]    wval_ext;

  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_op_r  <= in_op;
      item_row_r <= in_tdata[ROW_LSB +: IDX_W];
      item_col_r <= in_tdata[COL_LSB +: IDX_W];
      item_val_r <= in_tdata[VAL_LSB +: CELL_W];
    end
  end

  assign item_addr = AW'(32'(item_row_r) * MAX_COLS + 32'(item_col_r));
  assign item_bad  = (SZW'(item_row_r) >= used_rows) || (SZW'(item_col_r) >= used_cols);
  assign wval_ext  = MW'(item_val_r);

  // sweep stream counters
  logic [AW-1:0] addr_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic          col_end;

  assign col_end = (col_r == CW'(MAX_COLS - 1));

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      addr_r <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (cmd.sweep_step) begin
      addr_r <= addr_r + AW'(1);
      col_r  <= col_end ? '0 : col_r + CW'(1);
      if (col_end) begin
        row_r <= row_r + RW'(1);
      end
    end
  end

  assign status.sweep_last = col_end && (SZW'(row_r) == last_row);

  // grid buffers
  logic [VALUE_BITS-1:0] mem0 [0:CELLS-1];
  logic [VALUE_BITS-1:0] mem1 [0:CELLS-1];
  logic [VALUE_BITS-1:0] rd0_r, rd1_r;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic                  we0, we1, host_wr;
  logic                  sel_r;
  logic signed [VALUE_BITS-1:0] cur_data;

  // stencil pipeline registers
  logic                         v1_r, v2_r, v3_r, v4_r;
  logic [RW-1:0]                row1_r, row2_r;
  logic [CW-1:0]                col1_r, col2_r;
  logic [AW-1:0]                addr1_r, addr2_r, waddr3_r;
  logic signed [VALUE_BITS-1:0] line_r [0:TAPS-1];
  logic signed [VALUE_BITS-1:0] q3_r, base3_r;
  logic [VALUE_BITS-1:0]        diff4_r, best_r;

  assign rd_addr  = cmd.sweep_step ? addr_r : item_addr;
  assign host_wr  = cmd.access && (item_op_r == OP_WRITE) && !item_bad;
  assign wr_addr  = host_wr ? item_addr : waddr3_r;
  assign wr_data  = host_wr ? wval_ext[VALUE_BITS-1:0] : q3_r;
  // the sweep writes the buffer that is not current
  assign we0      = host_wr || (v3_r && sel_r);
  assign we1      = host_wr || (v3_r && !sel_r);
  assign cur_data = sel_r ? rd1_r : rd0_r;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= wr_data;
    end
    rd0_r <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wr_addr] <= wr_data;
    end
    rd1_r <= mem1[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else if (cmd.swap) begin
      sel_r <= !sel_r;
    end
  end

  // stage 1: read issued, data lands in rd0_r/rd1_r
  always_ff @(posedge clk) begin
    row1_r  <= row_r;
    col1_r  <= col_r;
    addr1_r <= addr_r;
  end

  // stage 2: shift into line buffer; newest tap is the cell below the center
  always_ff @(posedge clk) begin
    if (v1_r) begin
      line_r[0] <= cur_data;
      for (int i = 1; i < TAPS; i++) begin
        line_r[i] <= line_r[i-1];
      end
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      addr2_r <= addr1_r;
    end
  end

  // stage 3: four-neighbor sum, floor divide by four
  logic signed [VALUE_BITS+1:0] nb_sum;
  logic                         interior;

  assign nb_sum = (VALUE_BITS+2)'(line_r[0]) + (VALUE_BITS+2)'(line_r[TAPS-1])
                + (VALUE_BITS+2)'(line_r[MAX_COLS-1]) + (VALUE_BITS+2)'(line_r[MAX_COLS+1]);

  // center row is one behind the stream row
  assign interior = ((SZW+1)'(row2_r) >= (SZW+1)'(2))
                 && ((SZW+1)'(row2_r) + (SZW+1)'(1) <= (SZW+1)'(used_rows))
                 && (col2_r != '0)
                 && ((SZW+1)'(col2_r) + (SZW+1)'(2) <= (SZW+1)'(used_cols));

  always_ff @(posedge clk) begin
    q3_r     <= VALUE_BITS'(nb_sum >>> 2);
    base3_r  <= line_r[MAX_COLS];
    waddr3_r <= addr2_r - AW'(MAX_COLS);
  end

  // stage 4: absolute change
  logic signed [VALUE_BITS:0] delta;
  logic signed [VALUE_BITS:0] delta_abs;

  assign delta     = (VALUE_BITS+1)'(q3_r) - (VALUE_BITS+1)'(base3_r);
  assign delta_abs = delta[VALUE_BITS] ? -delta : delta;

  always_ff @(posedge clk) begin
    diff4_r <= delta_abs[VALUE_BITS-1:0];
  end

  // stage 5: running maximum
  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      best_r <= '0;
    end else if (v4_r && (diff4_r > best_r)) begin
      best_r <= diff4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.sweep_step;
      v2_r <= v1_r;
      v3_r <= v2_r && interior;
      v4_r <= v3_r;
    end
  end

  assign status.pipe_empty = !(v1_r || v2_r || v3_r || v4_r);

  // result register
  logic [MW-1:0]            best_ext;
  logic signed [MW-1:0]     rd_ext;
  logic [CELL_W-1:0]        best_sat;
  logic [CELL_W-1:0]        read_value_r, max_change_r;
  logic                     bad_address_r;
  logic                     is_access;

  assign best_ext  = MW'(best_r);
  assign best_sat  = ((best_ext >> CELL_W) != '0) ? '1 : best_ext[CELL_W-1:0];
  assign rd_ext    = MW'(cur_data);
  assign is_access = (item_op_r == OP_WRITE) || (item_op_r == OP_READ);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_value_r  <= ((item_op_r == OP_READ) && !item_bad) ? rd_ext[CELL_W-1:0] : '0;
      max_change_r  <= (item_op_r == OP_SWEEP) ? best_sat : '0;
      bad_address_r <= is_access && item_bad;
    end
  end

  assign read_value  = read_value_r;
  assign max_change  = max_change_r;
  assign bad_address = bad_address_r;

endmodule
`default_nettype wire

FILE: rtl/jacobi_laplace_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_laplace_sweep
// Two-buffer grid with cell write/read and a five-point Jacobi sweep.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives exactly one result item. A
// write or a read passes through the access state and has its result loaded
// once the output register is free; the next item is accepted after that. A
// sweep streams the current buffer through its single read port in raster
// order, one cell per cycle, over the rows in use (grid_rows saturated at
// MAX_ROWS, at least one) of MAX_COLS cells each, then drains the stencil
// pipeline and swaps the buffers before its result is loaded; a two-row line
// buffer supplies the stencil neighbors. The next item is accepted while a
// finished result still waits in the output register.
// Cells read before they are written give undefined data; no clearing pass
// is run after reset. Configuration writes are always taken.
module jacobi_laplace_sweep #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // row_index[5:0], col_index[11:6], cell_value[43:12], zero pad
  input  wire logic [jls_pkg::IN_TDATA_W-1:0]      in_tdata,
  // operation[1:0]
  input  wire logic [jls_pkg::OP_W-1:0]            in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // read_value[31:0], max_change[63:32]
  output logic [jls_pkg::OUT_TDATA_W-1:0]          out_tdata,
  // bad_address[0]
  output logic                                     out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [jls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [jls_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import jls_pkg::*;

  op_t               in_op;
  cmd_t              cmd;
  status_t           status;
  logic [CELL_W-1:0] read_value, max_change;

  assign in_op     = op_t'(in_tuser);
  assign cfg_ready = 1'b1;
  assign out_tdata = {max_change, read_value};

  jls_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_op),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  jls_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_op       (in_op),
    .in_tdata    (in_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .read_value  (read_value),
    .max_change  (max_change),
    .bad_address (out_tuser)
  );

`ifndef SYNTH
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sweep_step |-> !in_tready)
    else $error("item accepted during sweep");

  a_swap_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.swap |-> status.pipe_empty)
    else $error("buffer swap with stencil pipeline busy");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.latch_item, cmd.access, cmd.sweep_step, cmd.swap, cmd.load_out}))
    else $error("conflicting datapath commands");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_tvalid)
    else $error("result loaded but not presented");
`endif

endmodule
`default_nettype wire
